FILE: hw/rtl/shn_pkg.sv
`default_nettype none
package shn_pkg;

    localparam int unsigned MAX_WIDTH  = 512;
    localparam int unsigned MAX_HEIGHT = 512;
    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned YW = $clog2(MAX_HEIGHT);
    localparam int unsigned AW = XW + YW;
    localparam int unsigned CFG_W = 10;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // request codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic       func;
        logic [8:0] x_pos;
        logic [8:0] y_pos;
        logic [7:0] height_sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] normal_x;
        logic [7:0] normal_y;
        logic [7:0] normal_z;
    } t_out_item;

    // classified request passed from front to back
    typedef struct packed {
        logic          query;
        logic [XW-1:0] x;
        logic [XW-1:0] xm;
        logic [XW-1:0] xp;
        logic [YW-1:0] y;
        logic [YW-1:0] ym;
        logic [YW-1:0] yp;
        logic [7:0]    hs;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_DIVSET,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/shn_front.sv
`default_nettype none
module shn_front import shn_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);
    logic [CFG_W-1:0] r_w, n_w, r_h, n_h;
    logic [CFG_W-1:0] w_x, w_y;
    logic inside_img;
    logic [1:0] r_cnt;
    t_cmd r_q [2];
    logic r_wp, r_rp;
    t_cmd c;

    // clamp register writes to 1..max
    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (i_cfg_we && i_cfg_idx == REG_IMAGE_WIDTH) begin
            n_w = (i_cfg_data == '0) ? CFG_W'(1) :
                  (i_cfg_data > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : i_cfg_data;
        end
        if (i_cfg_we && i_cfg_idx == REG_IMAGE_HEIGHT) begin
            n_h = (i_cfg_data == '0) ? CFG_W'(1) :
                  (i_cfg_data > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : i_cfg_data;
        end
    end

    // classify request, compute wrapped neighbors
    always_comb begin
        w_x = CFG_W'(i_item.x_pos);
        w_y = CFG_W'(i_item.y_pos);
        inside_img = (w_x < r_w) && (w_y < r_h);
        c.query = i_item.func == FUNC_QUERY;
        c.x  = XW'(i_item.x_pos);
        c.y  = YW'(i_item.y_pos);
        c.xm = (w_x == '0) ? XW'(r_w - 1'b1) : XW'(w_x - 1'b1);
        c.xp = (w_x + 1'b1 >= r_w) ? '0 : XW'(w_x + 1'b1);
        c.ym = (w_y == '0) ? YW'(r_h - 1'b1) : YW'(w_y - 1'b1);
        c.yp = (w_y + 1'b1 >= r_h) ? '0 : YW'(w_y + 1'b1);
        c.hs = i_item.height_sample;
    end

    assign o_ready     = r_cnt != 2'd2;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];

    // hold config and two-entry queue
    always_ff @(posedge i_clk) begin
        logic push, pop;
        push = i_valid && o_ready && inside_img;
        pop  = o_cmd_valid && i_cmd_ready;
        if (!i_rst_n) begin
            r_w <= CFG_W'(MAX_WIDTH);
            r_h <= CFG_W'(MAX_HEIGHT);
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            r_w <= n_w;
            r_h <= n_h;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= c;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/shn_back.sv
`default_nettype none
module shn_back import shn_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire t_cmd   i_cmd,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_item   o_item
);
    logic [7:0] r_mem [MAX_WIDTH*MAX_HEIGHT];
    t_state r_st, n_st;
    t_cmd r_cmd;
    logic [3:0] r_k;
    logic [7:0] r_rd;
    logic r_rdv;
    logic [7:0] r_p [9];
    logic signed [10:0] r_gx, r_gy;
    logic [21:0] r_sqx, r_sqy;
    // sqrt state (radicand < 2^38)
    logic [37:0] r_v, r_res, r_bit;
    logic [18:0] r_len;
    // division: three channels shared, one quotient bit a cycle
    logic [1:0] r_ch;
    logic [27:0] r_rem;
    logic [7:0] r_quo;
    logic [3:0] r_bc;
    logic [7:0] r_o [3];
    t_out_item r_out;
    logic r_ov;
    logic out_load;
    logic [AW-1:0] rd_addr;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic signed [11:0] c_val;
    logic [27:0] num;
    logic [19:0] den;

    // neighbor order: row ym, y, yp; col xm, x, xp
    always_comb begin
        unique case (r_k)
            4'd0, 4'd3, 4'd6: ax = r_cmd.xm;
            4'd1, 4'd4, 4'd7: ax = r_cmd.x;
            default:          ax = r_cmd.xp;
        endcase
        unique case (r_k)
            4'd0, 4'd1, 4'd2: ay = r_cmd.ym;
            4'd3, 4'd4, 4'd5: ay = r_cmd.y;
            default:          ay = r_cmd.yp;
        endcase
        rd_addr = {ay, ax};
    end

    always_comb begin
        unique case (r_ch)
            2'd0:    c_val = -12'(r_gx);
            2'd1:    c_val = -12'(r_gy);
            default: c_val = 12'sd255;
        endcase
        // c*256 + len, never negative, below 2^20
        num = {{8{c_val[11]}}, c_val, 8'd0} + {9'b0, r_len};
        den = {r_len, 1'b0};
    end

    assign o_cmd_ready = r_st == ST_IDLE;
    assign o_valid = r_ov;
    assign o_item = r_out;
    // move the finished normal out once the output slot frees up
    assign out_load = r_st == ST_OUT && (!r_ov || i_ready);

    // pick next phase
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (i_cmd_valid) n_st = i_cmd.query ? ST_READ : ST_IDLE;
            ST_READ:   if (r_k == 4'd9) n_st = ST_GRAD;
            ST_GRAD:   n_st = ST_SQUARE;
            ST_SQUARE: n_st = ST_SUM;
            ST_SUM:    n_st = ST_SQRT;
            ST_SQRT:   if (r_bit == '0) n_st = ST_DIVSET;
            ST_DIVSET: n_st = ST_DIV;
            ST_DIV:    if (r_bc == 4'd8) n_st = (r_ch == 2'd2) ? ST_OUT : ST_DIVSET;
            ST_OUT:    if (out_load) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_rdv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ov <= 1'b0;
            end
            r_rdv <= r_st == ST_READ && r_k != 4'd9;
        end
    end

    // hold the result for the output channel
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{normal_x: r_o[0], normal_y: r_o[1], normal_z: r_o[2]};
        end
    end

    // frame store: one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_cmd_valid && !i_cmd.query) begin
            r_mem[{i_cmd.y, i_cmd.x}] <= i_cmd.hs;
        end
        r_rd <= r_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_cmd <= i_cmd;
                r_k <= '0;
            end
            ST_READ: begin
                if (r_k != 4'd9) r_k <= r_k + 1'b1;
                if (r_rdv) r_p[r_k - 1'b1] <= r_rd;
            end
            ST_GRAD: begin
                r_gy <= 11'($signed({3'b0, r_p[0]}) + $signed({2'b0, r_p[1], 1'b0})
                     + $signed({3'b0, r_p[2]}) - $signed({3'b0, r_p[6]})
                     - $signed({2'b0, r_p[7], 1'b0}) - $signed({3'b0, r_p[8]}));
                r_gx <= 11'($signed({3'b0, r_p[2]}) + $signed({2'b0, r_p[5], 1'b0})
                     + $signed({3'b0, r_p[8]}) - $signed({3'b0, r_p[0]})
                     - $signed({2'b0, r_p[3], 1'b0}) - $signed({3'b0, r_p[6]}));
            end
            ST_SQUARE: begin
                r_sqx <= $signed({{11{r_gx[10]}}, r_gx}) * $signed({{11{r_gx[10]}}, r_gx});
                r_sqy <= $signed({{11{r_gy[10]}}, r_gy}) * $signed({{11{r_gy[10]}}, r_gy});
            end
            ST_SUM: begin
                r_v   <= {(22'(r_sqx + r_sqy) + 22'd65025), 16'd0};
                r_res <= '0;
                r_bit <= 38'd1 << 36;
            end
            ST_SQRT: begin
                if (r_bit != '0) begin
                    if (r_v >= r_res + r_bit) begin
                        r_v <= r_v - (r_res + r_bit);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_len <= r_res[18:0];
                    r_ch <= '0;
                end
            end
            ST_DIVSET: begin
                // quotient < 256, so num*255 = num*256 - num; shift bits out
                r_quo <= '0;
                r_bc <= '0;
                r_v <= 38'({num, 8'd0} - 36'(num));
            end
            ST_DIV: begin
                if (r_bc != 4'd8) begin
                    // long division over 36-bit dividend: preload high part
                    r_bc <= r_bc + 1'b1;
                end else begin
                    r_o[r_ch] <= r_quo;
                    r_ch <= r_ch + 1'b1;
                end
            end
            default: ;
        endcase
        // restoring division step shares ST_DIV
        if (r_st == ST_DIVSET) begin
            r_rem <= 28'(38'({num, 8'd0} - 36'(num)) >> 8);
        end
        if (r_st == ST_DIV && r_bc != 4'd8) begin
            if ({r_rem[26:0], r_v[7 - r_bc[2:0]]} >= 28'(den)) begin
                r_rem <= {r_rem[26:0], r_v[7 - r_bc[2:0]]} - 28'(den);
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_rem <= {r_rem[26:0], r_v[7 - r_bc[2:0]]};
                r_quo <= {r_quo[6:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sobel_height_to_normal_map.sv
`default_nettype none
// channel | direction | payload
// in      | i_valid/o_ready | t_in_item (func, x_pos, y_pos, height_sample)
// out     | o_valid/i_ready | t_out_item (normal_x, normal_y, normal_z)
// cfg     | i_cfg_we        | i_cfg_idx, i_cfg_data
// A write only updates the frame store in the back end; a query keeps it busy
// while it takes the request, reads the nine frame store values, forms the
// gradients, squares and sums them, takes the square root and divides
// once for each of the three output components.
// Synchronous active-low reset; the store is not cleared.
// A two-entry queue lets requests enter while the back end is busy; a normal
// waiting on the output stalls the back end only when the next one is done.
module sobel_height_to_normal_map import shn_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_item
);
    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    shn_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_item,
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    shn_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_item
    );
endmodule
`default_nettype wire

FILE: hw/rtl/shn_checker.sv
`default_nettype none
module shn_checker import shn_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_item
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item)) else $error("out hold");
    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("out after reset");
    // z component is always in upper half
    a_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.normal_z >= 8'd127) else $error("z low");
endmodule

bind sobel_height_to_normal_map shn_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_item
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import shn_pkg::*;

    localparam int LIMIT = 2_000_000;
    localparam int ROW   = 512;

    // height map shapes used through the run
    localparam int DIR_RANDOM = 0;
    localparam int DIR_FLAT   = 2;
    localparam int DIR_RIGHT  = 3;
    localparam int DIR_TOP    = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_ready;
    t_in_item             req_item;
    logic                 nrm_valid;
    logic                 nrm_ready;
    t_out_item            nrm_item;

    t_in_item  requests[$];
    t_out_item normals[$];
    logic [7:0] heights[ROW*ROW];
    bit         filled[ROW*ROW];
    int img_w = 512;
    int img_h = 512;
    int fails = 0;
    int cyc   = 0;
    bit calm  = 0;

    sobel_height_to_normal_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (req_valid),
        .o_ready    (req_ready),
        .i_item     (req_item),
        .o_valid    (nrm_valid),
        .i_ready    (nrm_ready),
        .o_item     (nrm_item)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report(input string what);
        fails++;
        $display("%0t: %s", $time, what);
    endtask

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // map one component from -len..len onto 0..255
    function automatic logic [7:0] to_byte(input longint c, input longint len);
        longint num;
        longint q;
        num = c * 256 + len;
        if (num <= 0 || len <= 0) return 8'd0;
        q = (num * 255) / (2 * len);
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic longint hgt(input int x, input int y);
        return longint'(heights[y*ROW + x]);
    endfunction

    function automatic t_out_item normal_at(input int x, input int y);
        int xm, xp, ym, yp;
        longint gx, gy, len;
        t_out_item r;
        xm = (x == 0) ? img_w - 1 : x - 1;
        xp = (x + 1 >= img_w) ? 0 : x + 1;
        ym = (y == 0) ? img_h - 1 : y - 1;
        yp = (y + 1 >= img_h) ? 0 : y + 1;
        gy = (hgt(xm, ym) + 2 * hgt(x, ym) + hgt(xp, ym))
           - (hgt(xm, yp) + 2 * hgt(x, yp) + hgt(xp, yp));
        gx = (hgt(xp, ym) + 2 * hgt(xp, y) + hgt(xp, yp))
           - (hgt(xm, ym) + 2 * hgt(xm, y) + hgt(xm, yp));
        len = longint'(int_root(longint'(gx * gx + gy * gy + 65025) << 16));
        r.normal_x = to_byte(-gx, len);
        r.normal_y = to_byte(-gy, len);
        r.normal_z = to_byte(255, len);
        return r;
    endfunction

    // update the height map or queue the expected normal for an accepted request
    task automatic absorb(input t_in_item it);
        if (it.x_pos < img_w && it.y_pos < img_h) begin
            if (it.func == FUNC_WRITE) heights[it.y_pos*ROW + it.x_pos] = it.height_sample;
            else normals.push_back(normal_at(it.x_pos, it.y_pos));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) absorb(req_item);
            if (!req_valid || req_ready) begin
                if (requests.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                    req_item  <= requests.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_out_item e;
        cyc++;
        if (cyc >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (!i_rst_n) begin
            nrm_ready <= 1'b0;
        end else begin
            if (nrm_valid && nrm_ready) begin
                if (normals.size() == 0) begin
                    report("normal with no query pending");
                end else begin
                    e = normals.pop_front();
                    if (nrm_item.normal_x !== e.normal_x)
                        report($sformatf("normal_x %0d, want %0d", nrm_item.normal_x, e.normal_x));
                    if (nrm_item.normal_y !== e.normal_y)
                        report($sformatf("normal_y %0d, want %0d", nrm_item.normal_y, e.normal_y));
                    if (nrm_item.normal_z !== e.normal_z)
                        report($sformatf("normal_z %0d, want %0d", nrm_item.normal_z, e.normal_z));
                end
            end
            nrm_ready <= calm || $urandom_range(99) >= 31;
        end
    end

    task automatic push_req(input logic f, input int x, input int y, input int h);
        t_in_item it;
        it.func = f;
        it.x_pos = x[8:0];
        it.y_pos = y[8:0];
        it.height_sample = h[7:0];
        if (f == FUNC_WRITE && x < img_w && y < img_h) filled[y*ROW + x] = 1'b1;
        requests.push_back(it);
    endtask

    function automatic bit hood_ready(input int x, input int y);
        int xm, xp, ym, yp;
        if (x >= img_w || y >= img_h) return 1'b1;
        xm = (x == 0) ? img_w - 1 : x - 1;
        xp = (x + 1 >= img_w) ? 0 : x + 1;
        ym = (y == 0) ? img_h - 1 : y - 1;
        yp = (y + 1 >= img_h) ? 0 : y + 1;
        return filled[ym*ROW+xm] && filled[ym*ROW+x] && filled[ym*ROW+xp]
            && filled[y*ROW+xm] && filled[y*ROW+x] && filled[y*ROW+xp]
            && filled[yp*ROW+xm] && filled[yp*ROW+x] && filled[yp*ROW+xp];
    endfunction

    // write the 3x3 neighborhood of a pixel (random shapes may skip cells already written), then query it
    task automatic hood(input int cx, input int cy, input int shape);
        int xs[3];
        int ys[3];
        int v;
        xs[0] = (cx == 0) ? img_w - 1 : cx - 1;
        xs[1] = cx;
        xs[2] = (cx + 1 >= img_w) ? 0 : cx + 1;
        ys[0] = (cy == 0) ? img_h - 1 : cy - 1;
        ys[1] = cy;
        ys[2] = (cy + 1 >= img_h) ? 0 : cy + 1;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                case (shape)
                    DIR_FLAT:  v = 255;
                    DIR_RIGHT: v = (i == 2) ? 255 : 0;
                    DIR_TOP:   v = (j == 0) ? 255 : 0;
                    default:   v = $urandom_range(255);
                endcase
                if (shape != DIR_RANDOM || !filled[ys[j]*ROW + xs[i]] || $urandom_range(1))
                    push_req(FUNC_WRITE, xs[i], ys[j], v);
            end
        end
        push_req(FUNC_QUERY, cx, cy, $urandom_range(255));
    endtask

    // wait until the block is idle, then load a new image size
    task automatic set_dims(input int w, input int h);
        while (requests.size() > 0 || req_valid || normals.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_IMAGE_WIDTH;
        cfg_data <= w[CFG_W-1:0];
        @(posedge i_clk);
        cfg_idx  <= REG_IMAGE_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        img_w = (w == 0) ? 1 : (w > 512) ? 512 : w;
        img_h = (h == 0) ? 1 : (h > 512) ? 512 : h;
    endtask

    function automatic int pick(input int lim);
        case ($urandom_range(3))
            0:       return 0;
            1:       return lim - 1;
            default: return $urandom_range(lim - 1);
        endcase
    endfunction

    task automatic random_part(input int n);
        int r, x, y;
        repeat (n) begin
            r = $urandom_range(99);
            x = $urandom_range(511);
            y = $urandom_range(511);
            if (r < 70) begin
                hood(pick(img_w), pick(img_h), DIR_RANDOM);
            end else if (r < 82) begin
                push_req(FUNC_WRITE, x, y, $urandom_range(255));
            end else begin
                if (r < 91) begin
                    x = pick(img_w);
                    y = pick(img_h);
                end
                if (hood_ready(x, y)) push_req(FUNC_QUERY, x, y, $urandom_range(255));
            end
        end
    endtask

    initial begin
        req_valid = 1'b0;
        req_item  = '0;
        nrm_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        i_rst_n   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners with wrap, steepest slopes, flat top
        set_dims(512, 512);
        hood(0, 0, DIR_RIGHT);
        hood(511, 511, DIR_TOP);
        hood(255, 256, DIR_FLAT);
        push_req(FUNC_QUERY, 0, 0, 255);

        set_dims(0, 1023);
        random_part(26);
        set_dims(1023, 0);
        random_part(26);
        set_dims(1, 1);
        random_part(20);
        set_dims(4, 4);
        random_part(32);
        set_dims(3, 5);
        random_part(32);
        set_dims(17, 2);
        random_part(32);
        set_dims(2, 9);
        random_part(32);
        set_dims(512, 512);
        random_part(40);
        set_dims(64, 40);
        calm = 1'b1;
        random_part(40);
        set_dims(511, 7);
        calm = 1'b0;
        random_part(40);

        while (requests.size() > 0 || req_valid || normals.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
